// ===== rtl/hpe_pkg.sv =====
// shared constants and controller/datapath interface types for the horner evaluator
package hpe_pkg;

    localparam int DATA_W        = 32;
    localparam int TERM_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int DEF_MAX_TERMS = 7;
    localparam int DEF_FRAC_BITS = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE  = 3'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic              load;
        logic              mul;
        logic              rnd;
        logic              add;
        logic              emit;
        logic [TERM_W-1:0] coef_sel;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [TERM_W-1:0] last_idx;
    } t_status;

endpackage

// ===== rtl/hpe_dp.sv =====
// datapath: configuration registers, shared multiply, round/saturate and add unit
module hpe_dp import hpe_pkg::*; #(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic signed [DATA_W-1:0] i_point,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_overflow
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam logic signed [PROD_W-1:0] HALF = (PROD_W'(1) << FRAC_BITS) >> 1;
    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic        [TERM_W-1:0]  r_last_idx;
    logic signed [DATA_W-1:0]  r_coef [MAX_TERMS];
    logic signed [DATA_W-1:0]  r_acc;
    logic signed [DATA_W-1:0]  r_x;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_ovf;
    logic signed [DATA_W-1:0]  r_value;
    logic                      r_value_ovf;

    logic        [TERM_W-1:0]  n_last_idx;
    logic        [TERM_W-1:0]  cfg_coef_idx;
    logic signed [DATA_W-1:0]  coef_rd;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [PROD_W-1:0]  prod_shr;
    logic                      rnd_ovf;
    logic signed [DATA_W-1:0]  rnd_val;
    logic signed [DATA_W:0]    sum;
    logic                      add_ovf;
    logic signed [DATA_W-1:0]  add_val;

    // zero terms act as one, more than the storage holds is clamped
    always_comb begin
        n_last_idx = i_cfg_data[TERM_W-1:0];
        if (n_last_idx == '0) begin
            n_last_idx = TERM_W'(1);
        end
        if (int'(n_last_idx) > MAX_TERMS) begin
            n_last_idx = TERM_W'(MAX_TERMS);
        end
        n_last_idx = n_last_idx - TERM_W'(1);
    end

    assign cfg_coef_idx = i_cfg_idx - CFG_COEF_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= '0;
            for (int i = 0; i < MAX_TERMS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TERM_COUNT) begin
                r_last_idx <= n_last_idx;
            end else if (int'(cfg_coef_idx) < MAX_TERMS) begin
                r_coef[cfg_coef_idx[IDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

    assign coef_rd = r_coef[i_cmd.coef_sel[IDX_W-1:0]];

    // round to nearest with ties up, then clamp to 32 bits
    always_comb begin
        prod_rnd = r_prod + HALF;
        prod_shr = prod_rnd >>> FRAC_BITS;
        rnd_ovf  = !((&prod_shr[PROD_W-1:DATA_W-1]) || !(|prod_shr[PROD_W-1:DATA_W-1]));
        if (rnd_ovf) begin
            rnd_val = prod_shr[PROD_W-1] ? Q_MIN : Q_MAX;
        end else begin
            rnd_val = prod_shr[DATA_W-1:0];
        end
    end

    always_comb begin
        sum     = {r_acc[DATA_W-1], r_acc} + {coef_rd[DATA_W-1], coef_rd};
        add_ovf = sum[DATA_W] ^ sum[DATA_W-1];
        if (add_ovf) begin
            add_val = sum[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
            add_val = sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= coef_rd;
            r_x   <= i_point;
            r_ovf <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod <= r_acc * r_x;
        end
        if (i_cmd.rnd) begin
            r_acc <= rnd_val;
            r_ovf <= r_ovf | rnd_ovf;
        end
        if (i_cmd.add) begin
            r_acc <= add_val;
            r_ovf <= r_ovf | add_ovf;
        end
        if (i_cmd.emit) begin
            r_value     <= r_acc;
            r_value_ovf <= r_ovf;
        end
    end

    assign o_status.last_idx = r_last_idx;
    assign o_value           = r_value;
    assign o_overflow        = r_value_ovf;

endmodule

// ===== rtl/hpe_ctrl.sv =====
// controller: sequences multiply, round and add steps per term and owns the handshakes
module hpe_ctrl import hpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_ADD,
        ST_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [TERM_W-1:0] r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic              in_xfer;
    logic              out_free;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.coef_sel = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.coef_sel = i_status.last_idx;
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_idx      = i_status.last_idx;
                    n_state    = (i_status.last_idx == '0) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_RND;
            end
            ST_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add      = 1'b1;
                o_cmd.coef_sel = r_idx - TERM_W'(1);
                n_idx          = r_idx - TERM_W'(1);
                n_state        = (r_idx == TERM_W'(1)) ? ST_FIN : ST_MUL;
            end
            ST_FIN: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // no transfer is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/horner_polynomial_eval_unit.sv =====
// top level of the horner polynomial evaluator, signed fixed point
//
// Evaluates p(x) = coef_0 + coef_1*x + ... + coef_(n-1)*x^(n-1) by Horner's rule.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx;
// index 0 is the term count (1..7), indexes 1..7 are coef_0..coef_6.
// Write configuration only while the unit is idle.
// Input channel: i_in_valid / o_in_ready carry the point x; one transfer per item.
// Output channel: o_out_valid / i_out_ready carry the value and overflow flag.
// Each lower term runs through the shared unit in turn: multiply, round and
// clamp, add and clamp. The next point is taken only after the result has been
// copied to the output register, and it can be taken in the same cycle that the
// result shows on o_out_valid.
// The result sits in an output register: while the receiver stalls the next point
// is still taken and computed, and only its final copy to the output waits.
// Reset (synchronous, active low) sets the term count to 1, all coefficients to 0
// and drops both handshakes.
module horner_polynomial_eval_unit import hpe_pkg::*; #(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_point,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_overflow
);

    t_cmd    cmd;
    t_status status;

    hpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hpe_dp #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_point    (i_point),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_value    (o_value),
        .o_overflow (o_overflow)
    );

endmodule
